@@ src/i2cmrt_pkg.sv @@
// ----------------------------------------------------------------------------
// i2cmrt_pkg
// shared types and constants of the i2c register transfer master
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package i2cmrt_pkg;

   // write buffer geometry
   localparam int MAX_BYTES = 16;
   localparam int BUF_AW    = $clog2(MAX_BYTES);
   localparam int CNT_W     = 5;

   // register reset values
   localparam logic [15:0] STEP_TICKS_RESET = 16'd500;
   localparam logic [15:0] WRITE_GAP_RESET  = 16'd60000;

   // request operation codes
   localparam logic [1:0] OP_TICK  = 2'd0;
   localparam logic [1:0] OP_LOAD  = 2'd1;
   localparam logic [1:0] OP_START = 2'd2;

   // configuration register indexes
   localparam logic [1:0] CSR_STEP_TICKS   = 2'd0;
   localparam logic [1:0] CSR_SINGLE_BYTE  = 2'd1;
   localparam logic [1:0] CSR_WRITE_GAP    = 2'd2;

   typedef enum logic [2:0] {
      PH_IDLE,
      PH_START,
      PH_TX,
      PH_RX,
      PH_RACK,
      PH_STOP,
      PH_PAUSE,
      PH_GAP
   } phase_type;

   typedef enum logic [2:0] {
      K_SLAVE,
      K_ADDRH,
      K_ADDRL,
      K_DATA,
      K_SLAVE_RD
   } tx_kind_type;

   typedef enum logic [1:0] {
      S_FAIL,
      S_RESTART,
      S_END
   } stop_kind_type;

   typedef struct packed {
      logic [1:0]       op;
      logic             sda_in;
      logic             is_read;
      logic             two_byte_addr;
      logic [7:0]       slave_addr;
      logic [15:0]      reg_addr;
      logic [CNT_W-1:0] byte_count;
      logic [7:0]       write_byte;
   } req_type;

   typedef struct packed {
      logic       scl_out;
      logic       sda_out;
      logic       busy_res;
      logic       read_valid;
      logic [7:0] read_byte;
      logic       done_res;
      logic       success;
   } rsp_type;

   // write buffer control from the sequencer
   typedef struct packed {
      logic       push;
      logic       clear;
      logic [7:0] push_byte;
   } wbuf_ctrl_type;

endpackage

`default_nettype wire

@@ src/i2cmrt_write_buf.sv @@
// ----------------------------------------------------------------------------
// i2cmrt_write_buf
// write data buffer with fill count, appends while not full
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module i2cmrt_write_buf (
   input  wire                              clock,
   input  wire                              reset,
   input  wire i2cmrt_pkg::wbuf_ctrl_type   ctrl,
   input  wire [i2cmrt_pkg::CNT_W-1:0]      rd_index,
   output logic [7:0]                       rd_byte
);

   logic [7:0]                   mem_ff [i2cmrt_pkg::MAX_BYTES];
   logic [i2cmrt_pkg::CNT_W-1:0] count_ff;
   logic [i2cmrt_pkg::CNT_W-1:0] count_in;
   logic                         wr_en;

   localparam logic [i2cmrt_pkg::CNT_W-1:0] DEPTH =
      i2cmrt_pkg::CNT_W'(i2cmrt_pkg::MAX_BYTES);

   assign wr_en = ctrl.push && (count_ff < DEPTH);

   always_comb begin
      count_in = count_ff;
      if (ctrl.clear) begin
         count_in = '0;
      end else if (wr_en) begin
         count_in = count_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en && !ctrl.clear) begin
         mem_ff[count_ff[i2cmrt_pkg::BUF_AW-1:0]] <= ctrl.push_byte;
      end
   end

   assign rd_byte = (rd_index < DEPTH) ? mem_ff[rd_index[i2cmrt_pkg::BUF_AW-1:0]] : 8'd0;

endmodule

`default_nettype wire

@@ src/i2c_master_register_transfer.sv @@
// ----------------------------------------------------------------------------
// i2c_master_register_transfer
// tick driven i2c master for register reads and writes
// ----------------------------------------------------------------------------
//
//   channel | direction | handshake          | payload
//   --------+-----------+--------------------+-------------------------------
//   req     | in        | req_valid/req_stall| i2cmrt_pkg::req_type
//   rsp     | out       | rsp_valid/rsp_stall| i2cmrt_pkg::rsp_type
//   csr     | in        | csr_valid/csr_ready| csr_index (2b), csr_data (16b)
//
// one request per clock while req_stall is low: the request is decoded against the sequencer state
// in the cycle it is accepted and its response lands in the response register
// on the same edge, and rsp is driven from that register
// req_stall rises only while the response register is full and stalled
// csr is always ready; every request yields exactly one response
// synchronous active high reset: sequencer idle, lines scl low, sda released
//
`timescale 1ns / 1ps
`default_nettype none

module i2c_master_register_transfer (
   input  wire                          clock,
   input  wire                          reset,
   // request channel
   input  wire                          req_valid,
   output logic                         req_stall,
   input  wire i2cmrt_pkg::req_type     req_data,
   // response channel
   output logic                         rsp_valid,
   input  wire                          rsp_stall,
   output i2cmrt_pkg::rsp_type          rsp_data,
   // configuration writes
   input  wire                          csr_valid,
   output logic                         csr_ready,
   input  wire [1:0]                    csr_index,
   input  wire [15:0]                   csr_data
);

   localparam int CW = i2cmrt_pkg::CNT_W;
   localparam logic [CW-1:0] MAX_CNT = CW'(i2cmrt_pkg::MAX_BYTES);

   // configuration registers
   logic [15:0] step_ticks_ff;
   logic        single_cfg_ff;
   logic [15:0] write_gap_ff;

   // sequencer state
   i2cmrt_pkg::phase_type     phase_ff,     phase_in;
   logic [1:0]                sub_ff,       sub_in;
   logic [15:0]               tick_ff,      tick_in;
   logic [3:0]                bit_ff,       bit_in;
   logic [7:0]                shift_ff,     shift_in;
   logic [CW-1:0]             byte_idx_ff,  byte_idx_in;
   logic [7:0]                cmd_slave_ff, cmd_slave_in;
   logic [15:0]               cmd_reg_ff,   cmd_reg_in;
   logic                      cmd_rd_ff,    cmd_rd_in;
   logic                      cmd_two_ff,   cmd_two_in;
   logic [CW-1:0]             cmd_cnt_ff,   cmd_cnt_in;
   logic                      scl_ff,       scl_in;
   logic                      sda_ff,       sda_in;
   i2cmrt_pkg::tx_kind_type   tx_kind_ff,   tx_kind_in;
   i2cmrt_pkg::stop_kind_type stop_kind_ff, stop_kind_in;
   logic                      reread_ff,    reread_in;
   logic                      single_ff,    single_in;
   logic                      ack_ok_ff,    ack_ok_in;

   // response register
   logic                      rsp_valid_ff;
   i2cmrt_pkg::rsp_type       rsp_data_ff,  rsp_data_in;

   // per request event flags
   logic                      accept;
   logic                      do_enter;
   i2cmrt_pkg::phase_type     enter_ph;
   logic [1:0]                enter_sub;
   logic                      do_send;
   i2cmrt_pkg::tx_kind_type   send_kind;
   logic                      do_stop;
   i2cmrt_pkg::stop_kind_type stop_sel;
   logic                      do_rx;
   logic                      do_finish;
   logic                      fin_ok;
   logic                      o_valid;
   logic [7:0]                o_byte;
   logic [CW-1:0]             cnt_sat;
   logic [15:0]               step_eff;
   logic [15:0]               tx_addr;
   logic [7:0]                rx_shift;
   logic [3:0]                rx_bit;
   logic [7:0]                buf_byte;
   i2cmrt_pkg::wbuf_ctrl_type wbuf_ctrl;

   assign accept    = req_valid && !req_stall;
   assign req_stall = rsp_valid_ff && rsp_stall;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;
   assign csr_ready = 1'b1;

   // a step length of zero behaves as one tick
   assign step_eff = (step_ticks_ff == 16'd0) ? 16'd1 : step_ticks_ff;
   assign cnt_sat  = (req_data.byte_count > MAX_CNT) ? MAX_CNT : req_data.byte_count;
   assign rx_shift = {shift_ff[6:0], req_data.sda_in};
   assign rx_bit   = bit_ff + 4'd1;

   // single byte mode walks the register address along with the byte index
   assign tx_addr = single_ff ? (cmd_reg_ff + {{(16 - CW){1'b0}}, byte_idx_in}) : cmd_reg_ff;

   // buffer loads and the clear on command start
   always_comb begin
      wbuf_ctrl.push      = accept && (phase_ff == i2cmrt_pkg::PH_IDLE)
                            && (req_data.op == i2cmrt_pkg::OP_LOAD);
      wbuf_ctrl.clear     = accept && (phase_ff == i2cmrt_pkg::PH_IDLE)
                            && (req_data.op == i2cmrt_pkg::OP_START);
      wbuf_ctrl.push_byte = req_data.write_byte;
   end

   i2cmrt_write_buf u_write_buf (
      .clock    (clock),
      .reset    (reset),
      .ctrl     (wbuf_ctrl),
      .rd_index (byte_idx_in),
      .rd_byte  (buf_byte)
   );

   // next state: sequencer transitions on each accepted request
   always_comb begin
      phase_in     = phase_ff;
      sub_in       = sub_ff;
      tick_in      = tick_ff;
      bit_in       = bit_ff;
      shift_in     = shift_ff;
      byte_idx_in  = byte_idx_ff;
      cmd_slave_in = cmd_slave_ff;
      cmd_reg_in   = cmd_reg_ff;
      cmd_rd_in    = cmd_rd_ff;
      cmd_two_in   = cmd_two_ff;
      cmd_cnt_in   = cmd_cnt_ff;
      tx_kind_in   = tx_kind_ff;
      stop_kind_in = stop_kind_ff;
      reread_in    = reread_ff;
      single_in    = single_ff;
      ack_ok_in    = ack_ok_ff;
      do_enter     = 1'b0;
      enter_ph     = phase_ff;
      enter_sub    = 2'd0;
      do_send      = 1'b0;
      send_kind    = i2cmrt_pkg::K_SLAVE;
      do_stop      = 1'b0;
      stop_sel     = i2cmrt_pkg::S_END;
      do_rx        = 1'b0;
      do_finish    = 1'b0;
      fin_ok       = 1'b0;
      o_valid      = 1'b0;
      o_byte       = 8'd0;

      if (accept) begin
         if (phase_ff == i2cmrt_pkg::PH_IDLE) begin
            if (req_data.op == i2cmrt_pkg::OP_START) begin
               cmd_rd_in    = req_data.is_read;
               cmd_two_in   = req_data.two_byte_addr;
               cmd_slave_in = req_data.slave_addr;
               cmd_reg_in   = req_data.reg_addr;
               cmd_cnt_in   = cnt_sat;
               single_in    = single_cfg_ff && !req_data.is_read;
               byte_idx_in  = '0;
               reread_in    = 1'b0;
               if (single_in && (cnt_sat == '0)) begin
                  do_finish = 1'b1;
                  fin_ok    = 1'b1;
               end else begin
                  do_enter = 1'b1;
                  enter_ph = i2cmrt_pkg::PH_START;
               end
            end
         end else if (req_data.op == i2cmrt_pkg::OP_TICK) begin
            if (tick_ff > 16'd1) begin
               tick_in = tick_ff - 16'd1;
            end else begin
               tick_in = '0;
               unique case (phase_ff)
                  i2cmrt_pkg::PH_START: begin
                     if (sub_ff < 2'd3) begin
                        do_enter  = 1'b1;
                        enter_sub = sub_ff + 2'd1;
                     end else begin
                        do_send   = 1'b1;
                        send_kind = reread_ff ? i2cmrt_pkg::K_SLAVE_RD : i2cmrt_pkg::K_SLAVE;
                     end
                  end
                  i2cmrt_pkg::PH_TX: begin
                     if (sub_ff < 2'd2) begin
                        // acknowledge sampled at the end of the scl high step
                        if (bit_ff >= 4'd8 && sub_ff == 2'd1) begin
                           ack_ok_in = !req_data.sda_in;
                        end
                        do_enter  = 1'b1;
                        enter_sub = sub_ff + 2'd1;
                     end else if (bit_ff < 4'd8) begin
                        shift_in = {shift_ff[6:0], 1'b0};
                        bit_in   = bit_ff + 4'd1;
                        do_enter = 1'b1;
                     end else if (!ack_ok_ff) begin
                        do_stop  = 1'b1;
                        stop_sel = i2cmrt_pkg::S_FAIL;
                     end else begin
                        unique case (tx_kind_ff)
                           i2cmrt_pkg::K_SLAVE: begin
                              do_send   = 1'b1;
                              send_kind = cmd_two_ff ? i2cmrt_pkg::K_ADDRH
                                                     : i2cmrt_pkg::K_ADDRL;
                           end
                           i2cmrt_pkg::K_ADDRH: begin
                              do_send   = 1'b1;
                              send_kind = i2cmrt_pkg::K_ADDRL;
                           end
                           i2cmrt_pkg::K_ADDRL: begin
                              if (cmd_rd_ff) begin
                                 do_stop  = 1'b1;
                                 stop_sel = i2cmrt_pkg::S_RESTART;
                              end else if (single_ff || byte_idx_ff < cmd_cnt_ff) begin
                                 do_send   = 1'b1;
                                 send_kind = i2cmrt_pkg::K_DATA;
                              end else begin
                                 do_stop = 1'b1;
                              end
                           end
                           i2cmrt_pkg::K_DATA: begin
                              if (single_ff) begin
                                 do_stop = 1'b1;
                              end else begin
                                 byte_idx_in = byte_idx_ff + 1'b1;
                                 if (byte_idx_in < cmd_cnt_ff) begin
                                    do_send   = 1'b1;
                                    send_kind = i2cmrt_pkg::K_DATA;
                                 end else begin
                                    do_stop = 1'b1;
                                 end
                              end
                           end
                           default: begin
                              // read address acknowledged: receive, or nack at once
                              byte_idx_in = '0;
                              if (cmd_cnt_ff != '0) begin
                                 do_rx = 1'b1;
                              end else begin
                                 do_enter = 1'b1;
                                 enter_ph = i2cmrt_pkg::PH_RACK;
                              end
                           end
                        endcase
                     end
                  end
                  i2cmrt_pkg::PH_RX: begin
                     if (bit_ff >= 4'd8) begin
                        do_enter = 1'b1;
                        enter_ph = i2cmrt_pkg::PH_RACK;
                     end else if (sub_ff == 2'd0) begin
                        do_enter  = 1'b1;
                        enter_sub = 2'd1;
                     end else begin
                        shift_in = rx_shift;
                        bit_in   = rx_bit;
                        if (rx_bit == 4'd8) begin
                           o_valid     = 1'b1;
                           o_byte      = rx_shift;
                           byte_idx_in = byte_idx_ff + 1'b1;
                        end
                        do_enter = 1'b1;
                     end
                  end
                  i2cmrt_pkg::PH_RACK: begin
                     if (sub_ff < 2'd2) begin
                        do_enter  = 1'b1;
                        enter_sub = sub_ff + 2'd1;
                     end else if (byte_idx_ff < cmd_cnt_ff) begin
                        do_rx = 1'b1;
                     end else begin
                        do_stop = 1'b1;
                     end
                  end
                  i2cmrt_pkg::PH_STOP: begin
                     if (sub_ff < 2'd2) begin
                        do_enter  = 1'b1;
                        enter_sub = sub_ff + 2'd1;
                     end else if (stop_kind_ff == i2cmrt_pkg::S_FAIL) begin
                        do_finish = 1'b1;
                     end else if (stop_kind_ff == i2cmrt_pkg::S_RESTART) begin
                        do_enter = 1'b1;
                        enter_ph = i2cmrt_pkg::PH_PAUSE;
                     end else begin
                        do_finish = 1'b1;
                        fin_ok    = 1'b1;
                        if (single_ff) begin
                           byte_idx_in = byte_idx_ff + 1'b1;
                           if (byte_idx_in < cmd_cnt_ff) begin
                              // next single byte transaction, after the gap if any
                              do_finish = 1'b0;
                              reread_in = 1'b0;
                              if (write_gap_ff == 16'd0) begin
                                 do_enter = 1'b1;
                                 enter_ph = i2cmrt_pkg::PH_START;
                              end else begin
                                 phase_in = i2cmrt_pkg::PH_GAP;
                                 sub_in   = 2'd0;
                                 tick_in  = write_gap_ff;
                              end
                           end
                        end
                     end
                  end
                  i2cmrt_pkg::PH_PAUSE: begin
                     reread_in = 1'b1;
                     do_enter  = 1'b1;
                     enter_ph  = i2cmrt_pkg::PH_START;
                  end
                  i2cmrt_pkg::PH_GAP: begin
                     reread_in = 1'b0;
                     do_enter  = 1'b1;
                     enter_ph  = i2cmrt_pkg::PH_START;
                  end
                  default: ;
               endcase
            end
         end
      end

      if (do_rx) begin
         bit_in   = '0;
         shift_in = '0;
         do_enter = 1'b1;
         enter_ph = i2cmrt_pkg::PH_RX;
      end
      if (do_send) begin
         tx_kind_in = send_kind;
         bit_in     = '0;
         case (send_kind)
            i2cmrt_pkg::K_SLAVE: shift_in = cmd_slave_ff;
            i2cmrt_pkg::K_ADDRH: shift_in = tx_addr[15:8];
            i2cmrt_pkg::K_ADDRL: shift_in = tx_addr[7:0];
            i2cmrt_pkg::K_DATA:  shift_in = buf_byte;
            default:             shift_in = cmd_slave_ff + 8'd1;
         endcase
         do_enter = 1'b1;
         enter_ph = i2cmrt_pkg::PH_TX;
      end
      if (do_stop) begin
         stop_kind_in = stop_sel;
         do_enter     = 1'b1;
         enter_ph     = i2cmrt_pkg::PH_STOP;
      end
      if (do_enter) begin
         phase_in = enter_ph;
         sub_in   = enter_sub;
         tick_in  = step_eff;
      end
      if (do_finish) begin
         phase_in = i2cmrt_pkg::PH_IDLE;
         tick_in  = '0;
      end
   end

   // outputs: line levels set by the step being entered, and the response
   always_comb begin
      scl_in = scl_ff;
      sda_in = sda_ff;
      if (do_enter) begin
         unique case (phase_in)
            i2cmrt_pkg::PH_START: begin
               case (sub_in)
                  2'd0:    sda_in = 1'b1;
                  2'd1:    scl_in = 1'b1;
                  2'd2:    sda_in = 1'b0;
                  default: scl_in = 1'b0;
               endcase
            end
            i2cmrt_pkg::PH_TX: begin
               case (sub_in)
                  2'd0:    sda_in = (bit_in < 4'd8) ? shift_in[7] : 1'b1;
                  2'd1:    scl_in = 1'b1;
                  default: scl_in = 1'b0;
               endcase
            end
            i2cmrt_pkg::PH_RX: begin
               if (bit_in < 4'd8 && sub_in == 2'd1) begin
                  scl_in = 1'b1;
               end else begin
                  scl_in = 1'b0;
                  if (bit_in < 4'd8) begin
                     sda_in = 1'b1;
                  end
               end
            end
            i2cmrt_pkg::PH_RACK: begin
               // nack after the last byte, ack otherwise
               case (sub_in)
                  2'd0:    sda_in = (byte_idx_in >= cmd_cnt_in);
                  2'd1:    scl_in = 1'b1;
                  default: scl_in = 1'b0;
               endcase
            end
            i2cmrt_pkg::PH_STOP: begin
               case (sub_in)
                  2'd0:    sda_in = 1'b0;
                  2'd1:    scl_in = 1'b1;
                  default: sda_in = 1'b1;
               endcase
            end
            default: ;
         endcase
      end

      rsp_data_in.scl_out    = scl_in;
      rsp_data_in.sda_out    = sda_in;
      rsp_data_in.busy_res   = (phase_in != i2cmrt_pkg::PH_IDLE);
      rsp_data_in.read_valid = o_valid;
      rsp_data_in.read_byte  = o_byte;
      rsp_data_in.done_res   = do_finish;
      rsp_data_in.success    = do_finish && fin_ok;
   end

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         step_ticks_ff <= i2cmrt_pkg::STEP_TICKS_RESET;
         single_cfg_ff <= 1'b0;
         write_gap_ff  <= i2cmrt_pkg::WRITE_GAP_RESET;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            i2cmrt_pkg::CSR_STEP_TICKS:  step_ticks_ff <= csr_data;
            i2cmrt_pkg::CSR_SINGLE_BYTE: single_cfg_ff <= csr_data[0];
            i2cmrt_pkg::CSR_WRITE_GAP:   write_gap_ff  <= csr_data;
            default: ;
         endcase
      end
   end

   // sequencer state
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= i2cmrt_pkg::PH_IDLE;
         sub_ff       <= '0;
         tick_ff      <= '0;
         bit_ff       <= '0;
         shift_ff     <= '0;
         byte_idx_ff  <= '0;
         cmd_slave_ff <= '0;
         cmd_reg_ff   <= '0;
         cmd_rd_ff    <= 1'b0;
         cmd_two_ff   <= 1'b0;
         cmd_cnt_ff   <= '0;
         scl_ff       <= 1'b0;
         sda_ff       <= 1'b1;
         tx_kind_ff   <= i2cmrt_pkg::K_SLAVE;
         stop_kind_ff <= i2cmrt_pkg::S_FAIL;
         reread_ff    <= 1'b0;
         single_ff    <= 1'b0;
         ack_ok_ff    <= 1'b0;
      end else begin
         phase_ff     <= phase_in;
         sub_ff       <= sub_in;
         tick_ff      <= tick_in;
         bit_ff       <= bit_in;
         shift_ff     <= shift_in;
         byte_idx_ff  <= byte_idx_in;
         cmd_slave_ff <= cmd_slave_in;
         cmd_reg_ff   <= cmd_reg_in;
         cmd_rd_ff    <= cmd_rd_in;
         cmd_two_ff   <= cmd_two_in;
         cmd_cnt_ff   <= cmd_cnt_in;
         scl_ff       <= scl_in;
         sda_ff       <= sda_in;
         tx_kind_ff   <= tx_kind_in;
         stop_kind_ff <= stop_kind_in;
         reread_ff    <= reread_in;
         single_ff    <= single_in;
         ack_ok_ff    <= ack_ok_in;
      end
   end

   // response register: loads on accept, empties when taken
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (accept) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

endmodule

`default_nettype wire
